// File: src/json_stream_reindenter_defines.svh
// ----------------------------------------------------------------------------
// json stream reindenter assertion macros
// shared property forms used by the top level checks
// ----------------------------------------------------------------------------
`ifndef JSON_STREAM_REINDENTER_DEFINES_SVH
`define JSON_STREAM_REINDENTER_DEFINES_SVH

// condition holds at every edge out of reset
`define JSR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define JSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/jsr_pkg.sv
// ----------------------------------------------------------------------------
// jsr_pkg
// shared types and byte codes of the json stream reindenter
// ----------------------------------------------------------------------------
package jsr_pkg;

    localparam int LEVEL_W = 5;
    localparam int IDX_W   = LEVEL_W + 1;
    localparam logic [LEVEL_W-1:0] MAX_DEPTH = 5'd31;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // shape of the byte run that one input word causes
    typedef enum logic [1:0] {
        CMD_PASS,         // the byte alone
        CMD_BYTE_SPACE,   // byte then space
        CMD_BYTE_INDENT,  // byte, newline, indentation
        CMD_INDENT_BYTE   // newline, indentation, byte
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;
        logic [LEVEL_W-1:0] level;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

// File: src/jsr_front.sv
// ----------------------------------------------------------------------------
// jsr_front
// accepts text bytes, tracks string and nesting state, issues run commands
// ----------------------------------------------------------------------------
module jsr_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [7:0]                in_byte,
    input  logic                      in_first,
    output logic                      in_ready,
    input  jsr_pkg::q_status_t        q_stat,
    output logic                      cmd_push,
    output jsr_pkg::cmd_t             cmd
);
    import jsr_pkg::*;

    logic               ins_reg, ins_next;
    logic               esc_reg, esc_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;

    logic               ins, esc;
    logic [LEVEL_W-1:0] lvl;
    logic               emit;
    logic               accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign cmd_push = accept && emit;

    always_comb begin
        // first byte of a text starts from a clean state
        ins = in_first ? 1'b0 : ins_reg;
        esc = in_first ? 1'b0 : esc_reg;
        lvl = in_first ? '0 : lvl_reg;

        ins_next  = ins;
        esc_next  = esc;
        lvl_next  = lvl;
        emit      = 1'b1;
        cmd.kind  = CMD_PASS;
        cmd.data  = in_byte;
        cmd.level = lvl;

        if (ins) begin
            if (esc) begin
                esc_next = 1'b0;
            end else if (in_byte == CH_BSLASH) begin
                esc_next = 1'b1;
            end else if (in_byte == CH_QUOTE) begin
                ins_next = 1'b0;
            end
        end else begin
            unique case (in_byte) inside
                CH_QUOTE: begin
                    ins_next = 1'b1;
                    esc_next = 1'b0;
                end
                CH_LBRACE, CH_LBRACKET: begin
                    if (lvl < MAX_DEPTH) begin
                        lvl_next = lvl + 1'b1;
                    end
                    cmd.kind  = CMD_BYTE_INDENT;
                    cmd.level = lvl_next;
                end
                CH_RBRACE, CH_RBRACKET: begin
                    if (lvl != '0) begin
                        lvl_next = lvl - 1'b1;
                    end
                    cmd.kind  = CMD_INDENT_BYTE;
                    cmd.level = lvl_next;
                end
                CH_COMMA: begin
                    cmd.kind = CMD_BYTE_INDENT;
                end
                CH_COLON: begin
                    cmd.kind = CMD_BYTE_SPACE;
                end
                CH_SPACE, CH_TAB, CH_NEWLINE, CH_CR: begin
                    emit = 1'b0;
                end
                default: begin
                    cmd.kind = CMD_PASS;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_reg <= 1'b0;
            esc_reg <= 1'b0;
            lvl_reg <= '0;
        end else if (accept) begin
            ins_reg <= ins_next;
            esc_reg <= esc_next;
            lvl_reg <= lvl_next;
        end
    end

endmodule

// File: src/jsr_queue.sv
// ----------------------------------------------------------------------------
// jsr_queue
// short command queue between classifier and emitter
// ----------------------------------------------------------------------------
module jsr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  jsr_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output jsr_pkg::cmd_t      head_cmd,
    output jsr_pkg::q_status_t q_stat
);
    import jsr_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == QCNT_W'(QDEPTH));
    assign head_cmd         = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/jsr_back.sv
// ----------------------------------------------------------------------------
// jsr_back
// walks the head command one output byte per cycle, while the output is not stalled, into an output register
// ----------------------------------------------------------------------------
module jsr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  jsr_pkg::q_status_t q_stat,
    input  jsr_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);
    import jsr_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             vld_reg, vld_next;
    logic [7:0]       dat_reg;
    logic             lst_reg;

    logic [IDX_W-1:0] last_idx;
    logic             is_last;
    logic             advance;
    logic             fire;
    logic [7:0]       cur_byte;

    assign advance = !vld_reg || m_tready;
    assign fire    = q_stat.not_empty && advance;
    assign is_last = (idx_reg == last_idx);
    assign pop     = fire && is_last;

    always_comb begin
        case (head_cmd.kind)
            CMD_PASS:       last_idx = '0;
            CMD_BYTE_SPACE: last_idx = IDX_W'(1);
            default:        last_idx = {head_cmd.level, 1'b1};
        endcase
    end

    always_comb begin
        cur_byte = CH_SPACE;
        case (head_cmd.kind)
            CMD_PASS: begin
                cur_byte = head_cmd.data;
            end
            CMD_BYTE_SPACE, CMD_BYTE_INDENT: begin
                if (idx_reg == '0) begin
                    cur_byte = head_cmd.data;
                end else if (idx_reg == IDX_W'(1) && head_cmd.kind == CMD_BYTE_INDENT) begin
                    cur_byte = CH_NEWLINE;
                end
            end
            default: begin
                if (idx_reg == '0) begin
                    cur_byte = CH_NEWLINE;
                end else if (is_last) begin
                    cur_byte = head_cmd.data;
                end
            end
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        if (fire) begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            dat_reg <= cur_byte;
            lst_reg <= is_last;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = dat_reg;
    assign m_tlast  = lst_reg;

endmodule

// File: src/json_stream_reindenter.sv
// ----------------------------------------------------------------------------
// json_stream_reindenter
// re-indents json text: strings pass verbatim, whitespace outside strings is
// dropped, braces, brackets and commas get a newline and indentation
// ----------------------------------------------------------------------------
// channel  dir  tdata                 tuser / tlast
// s_       in   [7:0] text byte       tuser: first byte of a text
// m_       out  [7:0] output byte     tlast: last byte of this input's run
//
// the front takes one byte per cycle while its 4-entry command queue has room
// the back emits one byte per cycle while m_tready allows; a word makes no
// bytes for dropped whitespace, 1 or 2 for most, and 2 + 2*level for
// structural bytes, up to 64
// synchronous reset clears string, escape and nesting state, the queue and
// the output valid flag; either side may stall without losing words
// ----------------------------------------------------------------------------
`include "json_stream_reindenter_defines.svh"

module json_stream_reindenter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tuser,   // [0] first_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import jsr_pkg::*;

    q_status_t q_stat;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      q_push;
    logic      q_pop;

    jsr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_first (s_tuser),
        .in_ready (s_tready),
        .q_stat   (q_stat),
        .cmd_push (q_push),
        .cmd      (push_cmd)
    );

    jsr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    jsr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head_cmd (head_cmd),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `JSR_ASSERT_IMP(a_no_push_when_full, q_push, !q_stat.full, "command pushed into full queue")
    `JSR_ASSERT_IMP(a_no_pop_when_empty, q_pop, q_stat.not_empty, "command popped from empty queue")
    `JSR_ASSERT_ALWAYS(a_ready_tracks_queue, s_tready == !q_stat.full, "input ready out of step")
    `JSR_ASSERT_IMP(a_idle_after_reset, $past(!aresetn), !m_tvalid, "output valid right after reset")

endmodule
